// ===== src/rasr_pkg.sv =====
// Package: shared types and codes for the rational add/sub/reduce unit.
`default_nettype none
package rasr_pkg;
    typedef enum logic [2:0] {
        CMD_ADD    = 3'd0,
        CMD_SUB    = 3'd1,
        CMD_FEQ    = 3'd2,
        CMD_IEQ    = 3'd3,
        CMD_REDUCE = 3'd4
    } t_cmd;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } t_in;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic signed [31:0] res_den;
        logic               is_equal;
        logic               undefined_error;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_SUM, S_EUC_START, S_EUC_WAIT, S_DN_START, S_DN_WAIT,
        S_DD_START, S_DD_WAIT, S_IEQ_START, S_IEQ_WAIT, S_DONE
    } t_state;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_MUL, OP_SUM, OP_EUC_DIV, OP_EUC_STEP, OP_DN_DIV,
        OP_DN_SAVE, OP_DD_DIV, OP_DD_SAVE, OP_IEQ_DIV, OP_IEQ_SAVE, OP_EMIT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_ctl;

    typedef struct packed {
        logic   div_done;
        logic   x_zero;
        logic   g_zero;
        logic   err;
        t_cmd   cmd;
        logic   cmd_valid;
    } t_sts;
endpackage
`default_nettype wire

// ===== src/rasr_div.sv =====
// Iterative signed truncating divider, one quotient bit per cycle.
`default_nettype none
module rasr_div #(
    parameter int W = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_a,
    input  wire logic [W-1:0] i_b,
    output logic              o_done,
    output logic [W-1:0]      o_quo,
    output logic [W-1:0]      o_rem
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_q, n_q;
    logic [W:0]    r_r, n_r;
    logic [W-1:0]  r_d, n_d;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic          r_qneg, n_qneg, r_rneg, n_rneg;
    logic [W:0]    trial;
    logic [W-1:0]  mag_a, mag_b;

    assign mag_a = i_a[W-1] ? (~i_a + 1'b1) : i_a;
    assign mag_b = i_b[W-1] ? (~i_b + 1'b1) : i_b;
    assign trial = {r_r[W-1:0], r_q[W-1]} - {1'b0, r_d};

    // restoring shift-subtract step
    always_comb begin
        n_q = r_q; n_r = r_r; n_d = r_d; n_cnt = r_cnt;
        n_busy = r_busy; n_done = 1'b0; n_qneg = r_qneg; n_rneg = r_rneg;
        if (i_start) begin
            n_q = mag_a; n_r = '0; n_d = mag_b; n_cnt = CW'(W);
            n_busy = 1'b1; n_qneg = i_a[W-1] ^ i_b[W-1]; n_rneg = i_a[W-1];
        end else if (r_busy) begin
            if (!trial[W]) begin
                n_r = trial;
                n_q = {r_q[W-2:0], 1'b1};
            end else begin
                n_r = {r_r[W-1:0], r_q[W-1]};
                n_q = {r_q[W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q <= n_q; r_r <= n_r; r_d <= n_d; r_qneg <= n_qneg; r_rneg <= n_rneg;
    end

    assign o_done = r_done;
    assign o_quo  = r_qneg ? (~r_q + 1'b1) : r_q;
    assign o_rem  = r_rneg ? (~r_r[W-1:0] + 1'b1) : r_r[W-1:0];
endmodule
`default_nettype wire

// ===== src/rasr_datapath.sv =====
// Datapath: operand registers, cross multiply, Euclid registers, divider.
`default_nettype none
module rasr_datapath #(
    parameter int W = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire rasr_pkg::t_in  i_in,
    input  wire rasr_pkg::t_ctl i_ctl,
    output rasr_pkg::t_sts      o_sts,
    output rasr_pkg::t_out      o_out,
    output logic                o_strobe
);
    import rasr_pkg::*;

    logic [W-1:0] r_an, r_ad, r_bn, r_bd;
    logic [W-1:0] r_p, r_q, r_num, r_den, r_x, r_y;
    logic [2:0]   r_cmd;
    logic         r_err, r_eq, r_strobe;
    logic [W-1:0] div_a, div_b, quo, rem;
    logic         div_start, div_done;
    logic [W-1:0] an_w, ad_w, bn_w, bd_w;

    // sign-extend or truncate 32-bit inputs to the word
    function automatic logic [W-1:0] fit(input logic [31:0] v);
        logic [63:0] e;
        e = {{32{v[31]}}, v};
        return e[W-1:0];
    endfunction

    function automatic logic [31:0] unfit(input logic [W-1:0] v);
        logic [W+31:0] e;
        e = {{32{v[W-1]}}, v};
        return e[31:0];
    endfunction

    assign an_w = fit(i_in.a_num);
    assign ad_w = fit(i_in.a_den);
    assign bn_w = fit(i_in.b_num);
    assign bd_w = fit(i_in.b_den);

    // divider operand select; the final divides use the GCD held in r_y
    always_comb begin
        div_start = 1'b0;
        div_a = r_y;
        div_b = r_x;
        case (i_ctl.op)
            OP_EUC_DIV: div_start = 1'b1;
            OP_DN_DIV: begin div_start = 1'b1; div_a = r_num; div_b = r_y; end
            OP_DD_DIV: begin div_start = 1'b1; div_a = r_den; div_b = r_y; end
            OP_IEQ_DIV: begin div_start = 1'b1; div_a = r_an; div_b = r_ad; end
            default: ;
        endcase
    end

    rasr_div #(.W(W)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_a(div_a), .i_b(div_b), .o_done(div_done), .o_quo(quo), .o_rem(rem)
    );

    // register updates per operation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (i_ctl.op == OP_EMIT);
        end
        case (i_ctl.op)
            OP_LOAD: begin
                r_cmd <= i_in.command;
                r_an <= an_w; r_ad <= ad_w; r_bn <= bn_w; r_bd <= bd_w;
                r_eq <= 1'b0;
                r_num <= an_w; r_den <= ad_w;
                r_x <= an_w; r_y <= ad_w;
                case (i_in.command)
                    CMD_ADD, CMD_SUB, CMD_FEQ: r_err <= (ad_w == '0) || (bd_w == '0);
                    CMD_IEQ, CMD_REDUCE:       r_err <= (ad_w == '0);
                    default:                   r_err <= 1'b0;
                endcase
            end
            OP_MUL: begin
                r_p <= W'(r_an * r_bd);
                r_q <= W'(r_bn * r_ad);
                r_den <= W'(r_ad * r_bd);
            end
            OP_SUM: begin
                r_num <= (r_cmd == CMD_SUB) ? (r_p - r_q) : (r_p + r_q);
                r_x   <= (r_cmd == CMD_SUB) ? (r_p - r_q) : (r_p + r_q);
                r_y   <= r_den;
                r_eq  <= (r_p == r_q);
            end
            OP_EUC_STEP: begin r_y <= r_x; r_x <= rem; end
            OP_DN_SAVE: r_num <= quo;
            OP_DD_SAVE: r_den <= quo;
            OP_IEQ_SAVE: r_eq <= (rem == '0) && (quo == r_bn);
            default: ;
        endcase
    end

    assign o_sts.div_done  = div_done;
    assign o_sts.x_zero    = (r_x == '0);
    assign o_sts.g_zero    = (r_y == '0);
    assign o_sts.err       = r_err;
    assign o_sts.cmd       = t_cmd'(r_cmd);
    assign o_sts.cmd_valid = (r_cmd <= 3'(CMD_REDUCE));

    // result formatting
    always_comb begin
        o_out.res_num = 32'd0;
        o_out.res_den = 32'd1;
        o_out.is_equal = 1'b0;
        o_out.undefined_error = r_err;
        if (!r_err) begin
            case (r_cmd)
                CMD_ADD, CMD_SUB, CMD_REDUCE: begin
                    o_out.res_num = unfit(r_num);
                    o_out.res_den = unfit(r_den);
                end
                CMD_FEQ, CMD_IEQ: o_out.is_equal = r_eq;
                default: ;
            endcase
        end
    end
    assign o_strobe = r_strobe;
endmodule
`default_nettype wire

// ===== src/rasr_ctrl.sv =====
// Controller: sequences multiply, Euclid loop and final divides, or the integer-equality divide.
`default_nettype none
module rasr_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire rasr_pkg::t_sts i_sts,
    output rasr_pkg::t_ctl      o_ctl,
    output logic                o_busy
);
    import rasr_pkg::*;

    t_state r_state, n_state;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_start) n_state = S_MUL;
            S_MUL: begin
                if (i_sts.err || !i_sts.cmd_valid) n_state = S_DONE;
                else if (i_sts.cmd == CMD_IEQ) n_state = S_IEQ_START;
                else if (i_sts.cmd == CMD_REDUCE) n_state = S_EUC_START;
                else n_state = S_SUM;
            end
            S_SUM: n_state = (i_sts.cmd == CMD_FEQ) ? S_DONE : S_EUC_START;
            S_EUC_START: n_state = i_sts.x_zero ?
                (i_sts.g_zero ? S_DONE : S_DN_START) : S_EUC_WAIT;
            S_EUC_WAIT: if (i_sts.div_done) n_state = S_EUC_START;
            S_DN_START: n_state = S_DN_WAIT;
            S_DN_WAIT: if (i_sts.div_done) n_state = S_DD_START;
            S_DD_START: n_state = S_DD_WAIT;
            S_DD_WAIT: if (i_sts.div_done) n_state = S_DONE;
            S_IEQ_START: n_state = S_IEQ_WAIT;
            S_IEQ_WAIT: if (i_sts.div_done) n_state = S_DONE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs; reduce keeps the loaded denominator, so no multiply there
    always_comb begin
        o_ctl.op = OP_NONE;
        case (r_state)
            S_IDLE: if (i_start) o_ctl.op = OP_LOAD;
            S_MUL: if (i_sts.cmd != CMD_REDUCE) o_ctl.op = OP_MUL;
            S_SUM: o_ctl.op = OP_SUM;
            S_EUC_START: if (!i_sts.x_zero) o_ctl.op = OP_EUC_DIV;
            S_EUC_WAIT: if (i_sts.div_done) o_ctl.op = OP_EUC_STEP;
            S_DN_START: o_ctl.op = OP_DN_DIV;
            S_DN_WAIT: if (i_sts.div_done) o_ctl.op = OP_DN_SAVE;
            S_DD_START: o_ctl.op = OP_DD_DIV;
            S_DD_WAIT: if (i_sts.div_done) o_ctl.op = OP_DD_SAVE;
            S_IEQ_START: o_ctl.op = OP_IEQ_DIV;
            S_IEQ_WAIT: if (i_sts.div_done) o_ctl.op = OP_IEQ_SAVE;
            S_DONE: o_ctl.op = OP_EMIT;
            default: ;
        endcase
    end
    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.op == OP_EMIT) |=> (r_state == S_IDLE)) else $error("emit");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.op == OP_LOAD) |-> !o_busy) else $error("load");
    a_start_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (r_state == S_MUL)) else $error("start");
endmodule
`default_nettype wire

// ===== src/rational_add_sub_reduce_top.sv =====
// Top level: rational add/subtract/compare/reduce unit.
// Throughput: one transaction at a time; busy stays high until the result strobe.
// The iterative one-bit-per-cycle divider dominates the run time (Euclid steps most).
// Reset: synchronous active low; returns to idle, no result pending.
// The result is shown for one cycle with o_done; the receiver cannot stall.
`default_nettype none
module rational_add_sub_reduce_top #(
    parameter int WORD_BITS = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire rasr_pkg::t_in  i_item,
    output rasr_pkg::t_out      o_result,
    output logic                o_done
);
    import rasr_pkg::*;

    t_ctl ctl;
    t_sts sts;

    rasr_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_sts(sts), .o_ctl(ctl), .o_busy(busy)
    );

    rasr_datapath #(.W(WORD_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_item), .i_ctl(ctl),
        .o_sts(sts), .o_out(o_result), .o_strobe(o_done)
    );
endmodule
`default_nettype wire
